@@ src/irqs_pkg.sv @@
// Shared types, constants and register codes of the requantize-and-scale block.
package irqs_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned ProdWidth  = 64;
   localparam int unsigned SumWidth   = 65;
   localparam int unsigned ShiftWidth = 6;
   localparam int unsigned AmtWidth   = 6;
   localparam int unsigned IndexWidth = 2;
   localparam int unsigned Latency    = 6;

   localparam logic signed [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic signed [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};

   // Double rounding: rounding constant of the doubling high multiply and its shift
   localparam logic [AmtWidth-1:0] HighMulShift = AmtWidth'(31);
   localparam logic signed [SumWidth-1:0] HighMulBias = SumWidth'(64'd1 << 30);

   typedef enum logic [IndexWidth-1:0] {
      REG_ROUNDING_MODE    = 2'd0,
      REG_SCALE_MULTIPLIER = 2'd1,
      REG_SCALE_SHIFT      = 2'd2
   } reg_index_type;

   typedef enum logic {
      MODE_SINGLE = 1'b0,
      MODE_DOUBLE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                       mode;
      logic signed [DataWidth-1:0]    mult;
      logic signed [ShiftWidth-1:0]   shift;
   } cfg_type;

   localparam mode_type                     ResetMode  = MODE_SINGLE;
   localparam logic signed [DataWidth-1:0]  ResetMult  = DataWidth'(32'd1073741824);
   localparam logic signed [ShiftWidth-1:0] ResetShift = '0;

endpackage

@@ src/irqs_csr.sv @@
// Configuration registers: rounding mode, Q31 multiplier and shift exponent.
module irqs_csr
   import irqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_ROUNDING_MODE:    cfg_in.mode  = mode_type'(csr_wdata[0]);
            REG_SCALE_MULTIPLIER: cfg_in.mult  = csr_wdata;
            REG_SCALE_SHIFT:      cfg_in.shift = csr_wdata[ShiftWidth-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= ResetMode;
         cfg_ff.mult  <= ResetMult;
         cfg_ff.shift <= ResetShift;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/irqs_mul.sv @@
// Stages 1 and 2: operand left shift for double rounding, then the 32x32 product.
module irqs_mul
   import irqs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        in_valid,
   input  logic signed [DataWidth-1:0] in_acc,
   output logic                        out_valid,
   output logic signed [ProdWidth-1:0] out_prod,
   output logic                        out_sat,
   output logic                        active
);

   logic                        v1_ff, v2_ff;
   logic signed [DataWidth-1:0] a_ff, a_in;
   logic [4:0]                  ls;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic                        sat_ff, sat_in;

   // Positive exponent only; wrap the shifted operand to 32 bits
   always_comb begin
      ls = (!cfg.shift[ShiftWidth-1] && (cfg.shift != '0)) ? cfg.shift[4:0] : 5'd0;
      a_in = (cfg.mode == MODE_DOUBLE) ? (in_acc << ls) : in_acc;
   end

   always_comb begin
      prod_in = ProdWidth'(a_ff) * ProdWidth'(cfg.mult);
      sat_in  = (a_ff == MinVal) && (cfg.mult == MinVal);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
      sat_ff  <= sat_in;
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_sat   = sat_ff;
   assign active    = v1_ff | v2_ff;

endmodule

@@ src/irqs_rnd.sv @@
// Stages 3 and 4: add the rounding bias, then arithmetic shift down to 32 bits.
module irqs_rnd
   import irqs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        in_valid,
   input  logic signed [ProdWidth-1:0] in_prod,
   input  logic                        in_sat,
   output logic                        out_valid,
   output logic signed [DataWidth-1:0] out_y,
   output logic                        active
);

   logic                        v3_ff, v4_ff;
   logic [ShiftWidth:0]         ts_wide;
   logic [AmtWidth-1:0]         ts;
   logic signed [SumWidth-1:0]  bias;
   logic signed [SumWidth-1:0]  sum_ff, sum_in;
   logic [AmtWidth-1:0]         amt_ff, amt_in;
   logic                        sat_ff, sat_in;
   logic signed [SumWidth-1:0]  shifted;
   logic signed [DataWidth-1:0] y_ff, y_in;

   // Single rounding: total shift is 31 - exponent, no bias when it is zero
   always_comb begin
      ts_wide = (ShiftWidth+1)'(31) - {cfg.shift[ShiftWidth-1], cfg.shift};
      ts      = ts_wide[AmtWidth-1:0];
      if (cfg.mode == MODE_DOUBLE) begin
         bias   = HighMulBias;
         amt_in = HighMulShift;
      end else begin
         bias   = (ts == '0) ? '0 : (SumWidth'(1) << (ts - AmtWidth'(1)));
         amt_in = ts;
      end
      sum_in = SumWidth'(in_prod) + bias;
      sat_in = in_sat && (cfg.mode == MODE_DOUBLE);
   end

   // Floor shift; for the high multiply this rounds the product to nearest, ties upward
   always_comb begin
      shifted = sum_ff >>> amt_ff;
      y_in    = sat_ff ? MaxVal : shifted[DataWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      amt_ff <= amt_in;
      sat_ff <= sat_in;
      y_ff   <= y_in;
   end

   assign out_valid = v4_ff;
   assign out_y     = y_ff;
   assign active    = v3_ff | v4_ff;

endmodule

@@ src/irqs_dpot.sv @@
// Stages 5 and 6: rounding divide by a power of two, then the output register.
module irqs_dpot
   import irqs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        in_valid,
   input  logic signed [DataWidth-1:0] in_y,
   output logic                        out_valid,
   output logic signed [DataWidth-1:0] out_scaled,
   output logic                        active
);

   logic                        v5_ff, v6_ff;
   logic [AmtWidth-1:0]         e;
   logic signed [DataWidth:0]   ys;
   logic signed [DataWidth:0]   q_full;
   logic [DataWidth:0]          mask, rem, thr;
   logic signed [DataWidth-1:0] q_ff, q_in;
   logic                        inc_ff, inc_in;
   logic signed [DataWidth-1:0] scaled_ff, scaled_in;

   // Right exponent only in double rounding with a non-positive shift
   always_comb begin
      if ((cfg.mode == MODE_DOUBLE) && (cfg.shift[ShiftWidth-1] || (cfg.shift == '0))) begin
         e = AmtWidth'(-cfg.shift);
      end else begin
         e = '0;
      end
      ys     = {in_y[DataWidth-1], in_y};
      q_full = ys >>> e;
      q_in   = q_full[DataWidth-1:0];
      mask   = ~({(DataWidth+1){1'b1}} << e);
      rem    = ys & mask;
      thr    = (mask >> 1) + {{DataWidth{1'b0}}, in_y[DataWidth-1]};
      inc_in = rem > thr;
   end

   assign scaled_in = q_ff + DataWidth'(inc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      inc_ff    <= inc_in;
      scaled_ff <= scaled_in;
   end

   assign out_valid  = v6_ff;
   assign out_scaled = scaled_ff;
   assign active     = v5_ff | v6_ff;

endmodule

@@ src/int32_requantize_scale.sv @@
// Top level of the int32 requantize-and-scale pipeline.
//
//   channel   ports                                     handshake
//   --------  ----------------------------------------  -----------------------------
//   input     start, busy, req_acc                      taken when start & !busy
//   result    rsp_valid, rsp_scaled                     one-cycle strobe, no stall
//   config    csr_valid, csr_ready, csr_index, csr_wdata  written when valid & ready
//
// One transaction enters per cycle while busy is low; each result passes through
// the six register stages (shift, multiply, bias add, down shift, power-of-two
// rounding, output register) before it appears on rsp_scaled.
// Reset is synchronous and empties the pipeline; the registers return to single
// rounding, multiplier 2^30, shift 0.
// csr_ready is high only while the pipeline is empty; busy is high while csr_valid is.
// The receiver cannot stall, so no stage ever holds.
module int32_requantize_scale
   import irqs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DataWidth-1:0] req_acc,
   output logic                        rsp_valid,
   output logic signed [DataWidth-1:0] rsp_scaled,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [IndexWidth-1:0]       csr_index,
   input  logic [DataWidth-1:0]        csr_wdata
);

   cfg_type                     cfg;
   logic                        accept;
   logic                        mul_valid, rnd_valid;
   logic signed [ProdWidth-1:0] mul_prod;
   logic                        mul_sat;
   logic signed [DataWidth-1:0] rnd_y;
   logic                        mul_active, rnd_active, dpot_active;

   assign busy      = csr_valid;
   assign accept    = start && !busy;
   assign csr_ready = !(mul_active || rnd_active || dpot_active);

   irqs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irqs_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (accept),
      .in_acc    (req_acc),
      .out_valid (mul_valid),
      .out_prod  (mul_prod),
      .out_sat   (mul_sat),
      .active    (mul_active)
   );

   irqs_rnd u_rnd (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mul_valid),
      .in_prod   (mul_prod),
      .in_sat    (mul_sat),
      .out_valid (rnd_valid),
      .out_y     (rnd_y),
      .active    (rnd_active)
   );

   irqs_dpot u_dpot (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (rnd_valid),
      .in_y       (rnd_y),
      .out_valid  (rsp_valid),
      .out_scaled (rsp_scaled),
      .active     (dpot_active)
   );

endmodule

@@ src/irqs_checker.sv @@
// Port-level checks of the requantize-and-scale block, bound to the top level.
module irqs_checker
   import irqs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   // Every taken transaction yields its result after the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("result missing after a taken transaction");

   // No result without a transaction taken the fixed latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without a matching transaction");

   // Hold off configuration while anything is in flight
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !csr_ready)
      else $error("configuration open with a transaction in flight");

   // Configuration opens again only once the last result has left
   assert property (@(posedge clock) disable iff (reset)
      $rose(csr_ready) |-> $past(rsp_valid))
      else $error("configuration opened before the pipeline drained");

endmodule

bind int32_requantize_scale irqs_checker u_irqs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_ready (csr_ready)
);
